@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/lpht_pkg.sv @@
// Types and constants of the linear-probing hash table.
package lpht_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned HASH_W       = 32;
    localparam int unsigned VAL_W        = 64;
    localparam int unsigned MAX_W        = 8;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned BIT_CNT_W    = 5;
    localparam logic [MAX_W-1:0] MAX_RESET = 8'd192;

    typedef enum logic [1:0] {
        REQ_GET   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_MISS = 2'd0,
        ST_HIT  = 2'd1,
        ST_NEW  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_req              req_type;
        logic [KEY_W-1:0]  key_id;
        logic [HASH_W-1:0] key_hash;
        logic [VAL_W-1:0]  value_in;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value_out;
    } t_out;

    typedef struct packed {
        t_mark            mark;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

endpackage

@@ hdl/lpht_ram.sv @@
// Single-port-write, registered-read slot memory.
module lpht_ram
    import lpht_pkg::*;
#(
    parameter int unsigned DEPTH  = CAPACITY_DEF,
    parameter int unsigned DATA_W = $bits(t_slot),
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hdl/linear_probe_hash_table.sv @@
// Top level of the linear-probing hash table with tombstones.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_stall    | i_in  (req_type, key_id, key_hash, value_in)
//  out      | o_out_valid / i_out_stall  | o_out (status, value_out)
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_data (max_occupied)
//
// Get, set and delete pass S_IDLE, S_PROBE (1 to CAPACITY slots probed) and S_DONE;
// the slot memory is read once per probed slot. When CAPACITY is not a power of two the
// start slot is reduced from key_hash by a reciprocal multiply, a back-multiply and one
// compare and subtract in S_MOD before probing.
// Clear sweeps all slots in S_CLEAR, one slot mark written per cycle.
// After reset the same sweep runs with o_in_stall high.
// A result waiting on i_out_stall holds the next item at its final cycle.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MAX_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned SLOT_W = $bits(t_slot);
    localparam bit          POW2   = ((1 << IDX_W) == CAPACITY);
    localparam logic [IDX_W:0]   CAP_V  = (IDX_W+1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_V = IDX_W'(CAPACITY - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(2);
    localparam logic [HASH_W-1:0] CAP_H = HASH_W'(CAPACITY);
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / CAPACITY);

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VAL_W-1:0]     r_val, n_val;
    logic [HASH_W-1:0]    r_hash, n_hash;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [2*HASH_W-1:0]  r_prod, n_prod;
    logic [IDX_W:0]       r_rem, n_rem;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic                 r_tomb_seen, n_tomb_seen;
    logic [IDX_W-1:0]     r_tomb_idx, n_tomb_idx;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [MAX_W-1:0]     r_max, n_max;
    t_out                 r_res, n_res;
    logic [IDX_W-1:0]     r_sweep, n_sweep;
    logic                 r_clr_reply, n_clr_reply;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic                w_accept;
    logic                w_out_free;
    logic                w_sweep_last;
    logic                w_mod_last;
    logic [2*HASH_W-1:0] w_prod;
    logic [HASH_W-1:0]   w_qc;
    logic [HASH_W-1:0]   w_diff;
    logic [IDX_W-1:0]    w_rem_n;
    logic [IDX_W:0]      w_idx_inc;
    logic [IDX_W-1:0]    w_idx_next;
    logic [SLOT_W-1:0]   w_rdata;
    t_slot               w_slot;
    logic                w_is_empty;
    logic                w_is_hit;
    logic                w_is_tomb;
    logic                w_last;
    logic                w_stop;
    logic                w_tomb_now;
    logic [IDX_W-1:0]    w_tomb_slot;
    logic [IDX_W-1:0]    w_ins_idx;
    logic                w_have;
    logic                w_fresh;
    logic                w_over;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    t_slot               w_wdata;
    logic [IDX_W-1:0]    w_raddr;

    lpht_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (SLOT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_sweep_last = (r_sweep == LAST_V);
    assign w_mod_last   = (r_bit == BIT_LAST);

    // Start slot by reciprocal: the quotient estimate is at most one low,
    // so the difference stays below twice CAPACITY and one subtract finishes it.
    assign w_prod  = {{HASH_W{1'b0}}, r_hash} * {{HASH_W{1'b0}}, RECIP};
    assign w_qc    = r_prod[2*HASH_W-1:HASH_W] * CAP_H;
    assign w_diff  = r_hash - w_qc;
    assign w_rem_n = (r_rem >= CAP_V) ? IDX_W'(r_rem - CAP_V) : r_rem[IDX_W-1:0];

    assign w_idx_inc  = {1'b0, r_idx} + 1'b1;
    assign w_idx_next = (w_idx_inc == CAP_V) ? '0 : w_idx_inc[IDX_W-1:0];

    // Probe decode on the slot just read
    assign w_slot      = t_slot'(w_rdata);
    assign w_is_empty  = (w_slot.mark == MARK_EMPTY);
    assign w_is_hit    = (w_slot.mark == MARK_LIVE) && (w_slot.key == r_key);
    assign w_is_tomb   = !w_is_empty && (w_slot.mark != MARK_LIVE);
    assign w_last      = (r_cnt == LAST_V);
    assign w_stop      = w_is_empty || w_is_hit || w_last;
    assign w_tomb_now  = r_tomb_seen || w_is_tomb;
    assign w_tomb_slot = r_tomb_seen ? r_tomb_idx : r_idx;
    assign w_ins_idx   = w_tomb_now ? w_tomb_slot : r_idx;
    assign w_have      = w_is_empty || w_tomb_now;
    assign w_fresh     = w_is_empty && !w_tomb_now;
    assign w_over      = (r_count + 1'b1) > {1'b0, r_max};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_sweep_last) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type == REQ_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (POW2) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_mod_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_stop) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs: input stall and memory port
    always_comb begin
        o_in_stall = 1'b1;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = t_slot'{mark: MARK_LIVE, key: r_key, value: r_val};
        w_raddr    = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = t_slot'{mark: MARK_EMPTY, key: '0, value: '0};
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_raddr    = i_in.key_hash[IDX_W-1:0];
            end
            S_MOD: begin
                w_raddr = w_rem_n;
            end
            S_PROBE: begin
                w_raddr = w_idx_next;
                if (w_stop) begin
                    case (r_req)
                        REQ_SET: begin
                            if (w_is_hit) begin
                                w_we = 1'b1;
                            end else if (w_have && !(w_fresh && w_over)) begin
                                w_we    = 1'b1;
                                w_waddr = w_ins_idx;
                            end
                        end
                        REQ_DEL: begin
                            if (w_is_hit) begin
                                w_we    = 1'b1;
                                w_wdata = t_slot'{mark: MARK_TOMB, key: w_slot.key,
                                                  value: w_slot.value};
                            end
                        end
                        default: w_we = 1'b0;
                    endcase
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    // Datapath registers
    always_comb begin
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_hash      = r_hash;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_tomb_seen = r_tomb_seen;
        n_tomb_idx  = r_tomb_idx;
        n_count     = r_count;
        n_max       = i_cfg_valid ? i_cfg_data : r_max;
        n_res       = r_res;
        n_sweep     = r_sweep;
        n_clr_reply = r_clr_reply;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (w_sweep_last) begin
                    n_count = '0;
                    n_res   = t_out'{status: ST_MISS, value_out: '0};
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req       = i_in.req_type;
                    n_key       = i_in.key_id;
                    n_val       = i_in.value_in;
                    n_hash      = i_in.key_hash;
                    n_bit       = '0;
                    n_rem       = '0;
                    n_idx       = i_in.key_hash[IDX_W-1:0];
                    n_cnt       = '0;
                    n_tomb_seen = 1'b0;
                    n_sweep     = '0;
                    n_clr_reply = 1'b1;
                end
            end
            S_MOD: begin
                // advance the three-step reduction: product, difference, subtract
                n_bit  = r_bit + 1'b1;
                n_prod = w_prod;
                n_rem  = w_diff[IDX_W:0];
                n_idx  = w_rem_n;
            end
            S_PROBE: begin
                if (!w_stop) begin
                    n_idx       = w_idx_next;
                    n_cnt       = r_cnt + 1'b1;
                    n_tomb_seen = w_tomb_now;
                    n_tomb_idx  = w_tomb_slot;
                end else begin
                    n_res = t_out'{status: ST_MISS, value_out: '0};
                    case (r_req)
                        REQ_GET: begin
                            if (w_is_hit) begin
                                n_res = t_out'{status: ST_HIT, value_out: w_slot.value};
                            end
                        end
                        REQ_SET: begin
                            if (w_is_hit) begin
                                n_res.status = ST_HIT;
                            end else if (!w_have || (w_fresh && w_over)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_res.status = ST_NEW;
                                if (w_fresh) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        REQ_DEL: begin
                            if (w_is_hit) begin
                                n_res.status = ST_HIT;
                            end
                        end
                        default: n_res.status = ST_MISS;
                    endcase
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: n_sweep = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_clr_reply <= 1'b0;
            r_count     <= '0;
            r_max       <= MAX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_clr_reply <= n_clr_reply;
            r_count     <= n_count;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_key       <= n_key;
        r_val       <= n_val;
        r_hash      <= n_hash;
        r_bit       <= n_bit;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_tomb_seen <= n_tomb_seen;
        r_tomb_idx  <= n_tomb_idx;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

@@ hdl/lpht_checker.sv @@
// Port-level checks of the hash table, bound to the top level.
`include "assert_macros.svh"

module lpht_checker
    import lpht_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in              i_in,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out             o_out,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [MAX_W-1:0] i_cfg_data
);

    // hold a stalled item
    `ASSERT_CLK(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid, "out item dropped")
    `ASSERT_CLK(a_out_stable, (o_out_valid && i_out_stall) |=> $stable(o_out), "out item changed")
    // the slot sweep follows every reset
    `ASSERT_ALWAYS(a_rst_sweep, !i_rst_n |=> o_in_stall, "input open during reset sweep")
    // one item at a time
    `ASSERT_CLK(a_one_item, (i_in_valid && !o_in_stall) |=> o_in_stall, "second item taken")
    `ASSERT_CLK(a_value_zero, (o_out_valid && o_out.status != ST_HIT) |-> o_out.value_out == '0,
                "value without hit")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

@@ test/tb_linear_probe_hash_table.sv @@
// Self-checking testbench for the linear-probing hash table with tombstones.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int unsigned TBL_SLOTS = CAPACITY_DEF;
    localparam int POOL = 32;
    localparam int N_PHASES = 12;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in              i_in = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [MAX_W-1:0] i_cfg_data = '0;

    linear_probe_hash_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the table
    t_mark            tbl_mark [TBL_SLOTS];
    logic [KEY_W-1:0] tbl_key  [TBL_SLOTS];
    logic [VAL_W-1:0] tbl_val  [TBL_SLOTS];
    logic [COUNT_W-1:0] tbl_used;
    logic [MAX_W-1:0]   tbl_limit;

    t_in  requests_pending [$];
    t_out answers_due [$];
    int   reqs_queued = 0;
    int   reqs_taken = 0;
    int   mismatches = 0;
    bit   in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Apply one request to the shadow table and return the answer it earns.
    function automatic t_out table_apply(t_in rq);
        t_out res;
        int   idx;
        int   n;
        int   first_tomb;
        int   slot;
        bit   hit;
        bit   open_slot;
        bit   fresh;
        res.status = ST_MISS;
        res.value_out = '0;
        if (rq.req_type == REQ_CLEAR) begin
            foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
            tbl_used = '0;
            return res;
        end
        idx = int'(rq.key_hash % TBL_SLOTS);
        first_tomb = -1;
        slot = 0;
        hit = 1'b0;
        open_slot = 1'b0;
        fresh = 1'b0;
        for (n = 0; n < TBL_SLOTS; n++) begin
            if (tbl_mark[idx] == MARK_EMPTY) begin
                open_slot = 1'b1;
                if (first_tomb >= 0) begin
                    slot = first_tomb;
                end else begin
                    slot = idx;
                    fresh = 1'b1;
                end
                break;
            end
            if (tbl_mark[idx] == MARK_LIVE && tbl_key[idx] == rq.key_id) begin
                hit = 1'b1;
                slot = idx;
                break;
            end
            if (tbl_mark[idx] == MARK_TOMB && first_tomb < 0) first_tomb = idx;
            idx = (idx + 1) % TBL_SLOTS;
        end
        // Probe wrapped all the way round: fall back to the first tombstone
        if (!hit && !open_slot && first_tomb >= 0) begin
            open_slot = 1'b1;
            slot = first_tomb;
        end
        case (rq.req_type)
            REQ_GET: begin
                if (hit) begin
                    res.status = ST_HIT;
                    res.value_out = tbl_val[slot];
                end
            end
            REQ_SET: begin
                if (hit) begin
                    tbl_val[slot] = rq.value_in;
                    res.status = ST_HIT;
                end else if (!open_slot || (fresh && int'(tbl_used) + 1 > int'(tbl_limit))) begin
                    res.status = ST_FULL;
                end else begin
                    if (fresh) tbl_used = tbl_used + 1'b1;
                    tbl_mark[slot] = MARK_LIVE;
                    tbl_key[slot] = rq.key_id;
                    tbl_val[slot] = rq.value_in;
                    res.status = ST_NEW;
                end
            end
            REQ_DEL: begin
                if (hit) begin
                    tbl_mark[slot] = MARK_TOMB;
                    res.status = ST_HIT;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_req(input t_req r, input logic [KEY_W-1:0] k,
                            input logic [HASH_W-1:0] h, input logic [VAL_W-1:0] v);
        t_in it;
        it.req_type = r;
        it.key_id = k;
        it.key_hash = h;
        it.value_in = v;
        requests_pending.push_back(it);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [MAX_W-1:0] v);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly set/get/delete on a small pool of clustered keys, some fresh inserts and noise.
    task automatic run_phase(input int n_items, input int n_fill);
        logic [KEY_W-1:0]  pool_key  [POOL];
        logic [HASH_W-1:0] pool_hash [POOL];
        logic [7:0]        base [3];
        logic [HASH_W-1:0] h;
        int                i;
        int                r;
        int                pick;
        base[0] = 8'hFE;
        base[1] = 8'h00;
        base[2] = 8'($urandom());
        for (i = 0; i < POOL; i++) begin
            pool_key[i] = $urandom();
            h = $urandom();
            h[7:0] = base[$urandom_range(0, 2)] + 8'($urandom_range(0, 3));
            pool_hash[i] = h;
        end
        repeat (n_fill) push_req(REQ_SET, $urandom(), $urandom(), rnd64());
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL - 1);
            if (r < 2) begin
                push_req(REQ_CLEAR, $urandom(), $urandom(), rnd64());
            end else if (r < 50) begin
                push_req(REQ_SET, pool_key[pick], pool_hash[pick], rnd64());
            end else if (r < 75) begin
                push_req(REQ_GET, pool_key[pick], pool_hash[pick], rnd64());
            end else if (r < 90) begin
                push_req(REQ_DEL, pool_key[pick], pool_hash[pick], rnd64());
            end else if (r < 95) begin
                h = $urandom();
                if ($urandom_range(0, 1)) h[7:0] = base[$urandom_range(0, 2)];
                push_req(REQ_SET, $urandom(), h, rnd64());
            end else begin
                push_req(t_req'($urandom_range(0, 2)), $urandom(), $urandom(), rnd64());
            end
        end
    endtask

    // Monitor: check results, predict accepted items, track register writes.
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            foreach (tbl_mark[i]) begin
                tbl_mark[i] = MARK_EMPTY;
                tbl_key[i] = '0;
                tbl_val[i] = '0;
            end
            tbl_used = '0;
            tbl_limit = MAX_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d value_out %h",
                           o_out.status, o_out.value_out);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out.status);
                        mismatches++;
                    end
                    if (o_out.value_out !== want.value_out) begin
                        $error("value_out: expected %h, got %h", want.value_out,
                               o_out.value_out);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                answers_due.push_back(table_apply(i_in));
                reqs_taken++;
                in_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) tbl_limit = i_cfg_data;
        end
    end

    // Driver: hold an item until taken, then advance or idle.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in <= requests_pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin : main
        logic [MAX_W-1:0] limits [N_PHASES];
        int p;
        limits = '{8'd255, 8'd1, 8'd0, 8'd200, 8'd8, 8'd64,
                   8'd255, 8'd16, 8'd3, 8'd200, 8'd128, 8'd192};
        send_idle_pct = 19;
        recv_stall_pct = 54;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Collisions, key zero, update, delete, tombstone skip and reuse, wraparound, clear
        push_req(REQ_GET,   32'd1, 32'h0000_0000, rnd64());
        push_req(REQ_SET,   32'd1, 32'h0000_0000, '1);
        push_req(REQ_SET,   32'd2, 32'hFFFF_FF00, '0);
        push_req(REQ_SET,   32'd0, 32'h0000_0000, 64'h8000_0000_0000_0001);
        push_req(REQ_GET,   32'd0, 32'h0000_0000, rnd64());
        push_req(REQ_GET,   32'd2, 32'hFFFF_FF00, rnd64());
        push_req(REQ_SET,   32'd1, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
        push_req(REQ_GET,   32'd1, 32'h0000_0000, rnd64());
        push_req(REQ_DEL,   32'd1, 32'h0000_0000, rnd64());
        push_req(REQ_DEL,   32'd1, 32'h0000_0000, rnd64());
        push_req(REQ_GET,   32'd2, 32'h0000_0000, rnd64());
        push_req(REQ_SET,   32'd3, 32'h0000_0000, 64'hFEDC_BA98_7654_3210);
        push_req(REQ_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        push_req(REQ_SET,   32'd5, 32'h0000_00FF, 64'h5555_AAAA_5555_AAAA);
        push_req(REQ_GET,   32'd5, 32'h0000_00FF, rnd64());
        push_req(REQ_GET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, rnd64());
        push_req(REQ_DEL,   32'd7, 32'h0000_0080, rnd64());
        push_req(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        push_req(REQ_GET,   32'd2, 32'h0000_0000, rnd64());

        // Limit of one: reject a fresh slot, but let a tombstone be reused
        write_limit(8'd1);
        push_req(REQ_SET,   32'd10, 32'h0000_0010, rnd64());
        push_req(REQ_SET,   32'd11, 32'h0000_0010, rnd64());
        push_req(REQ_DEL,   32'd10, 32'h0000_0010, rnd64());
        push_req(REQ_SET,   32'd11, 32'h0000_0010, rnd64());
        push_req(REQ_CLEAR, 32'd0, 32'd0, '0);

        for (p = 0; p < N_PHASES; p++) begin
            write_limit(limits[p]);
            if (p < 4) begin
                send_idle_pct = 19;
                recv_stall_pct = 54;
            end else if (p < 8) begin
                send_idle_pct = 54;
                recv_stall_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            run_phase(125, (limits[p] == 8'd200) ? 210 : 0);
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d results never arrived", answers_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ linear_probe_hash_table.f @@
+incdir+hdl
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/linear_probe_hash_table.sv
hdl/lpht_checker.sv
test/tb_linear_probe_hash_table.sv
